// ===== rtl/nhcd_pkg.sv =====
// Package for the histogram chi-square distance block.
// Holds field widths and shared constants; no dependencies.
package nhcd_pkg;
    localparam int BIN_W      = 24;
    localparam int DIST_W     = 25;
    localparam int MAX_BINS_D = 64;
    localparam int Q_W        = 32;   // normalized bin, Q1.31 (value <= 2^31)
    localparam int ACC_W      = 64;
    localparam logic [DIST_W-1:0] ONE_Q24 = 25'd16777216;
endpackage

// ===== rtl/normalized_histogram_chi2_distance.sv =====
// Top level of the symmetric chi-square histogram distance.
// Depends on nhcd_pkg, nhcd_mem and nhcd_div.
//
// Each bin pair beat up to MAX_BINS is stored in the RAM. On the beat with
// tlast the block walks the stored bins: per bin a RAM read, two 57-bit
// normalizing divisions on one serial divider and a 64-bit term division
// on a second one, skipped when both bins are zero; after the last bin the
// result is loaded into the output register. The input is held off during
// the walk and while a finished result waits for the old one to leave the
// output. Bin storage is a RAM of MAX_BINS entries, no clearing pass.
module normalized_histogram_chi2_distance import nhcd_pkg::*; #(
    parameter int MAX_BINS = MAX_BINS_D
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // bin_a[23:0], bin_b[47:24]
    input  logic        s_tlast,   // last_bin
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // distance[24:0], zero fill
    output logic        m_tuser    // empty_input
);
    localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CW = $clog2(MAX_BINS + 1);
    localparam int IW = BIN_W + CW;
    localparam int NW = BIN_W + 33;

    typedef enum logic [2:0] {
        S_LOAD, S_RD, S_FETCH, S_NA, S_NB, S_TERM, S_OUT
    } state_t;

    state_t         state_reg;
    logic [CW-1:0]  cnt_reg, idx_reg;
    logic [IW-1:0]  ia_reg, ib_reg;
    logic [Q_W-1:0] na_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [BIN_W-1:0] rb_reg;
    logic           dvalid_reg, duser_reg;
    logic [DIST_W-1:0] dist_reg;
    logic           go_reg;
    logic [NW-1:0]  dnum_reg;
    logic [ACC_W-1:0] tnum_reg;
    logic [Q_W:0]   tden_reg;
    logic           tgo_reg;

    logic            acc_in, full, empty_in, out_load;
    logic [2*BIN_W-1:0] rdata;
    logic            ndone, tdone;
    logic [NW-1:0]   nquot;
    logic [ACC_W-1:0] tquot;
    logic [ACC_W-1:0] fin;
    logic [Q_W-1:0]  nb, dd;

    assign s_tready = (state_reg == S_LOAD);
    assign acc_in   = s_tvalid && s_tready;
    assign full     = (cnt_reg == CW'(MAX_BINS));
    assign empty_in = (ia_reg == '0) || (ib_reg == '0);
    // a finished result moves to the output once the old one is gone
    assign out_load = (state_reg == S_OUT) && (!dvalid_reg || m_tready);

    nhcd_mem #(.DEPTH(MAX_BINS)) u_mem (
        .clk(clk), .we(acc_in && !full), .waddr(cnt_reg[AW-1:0]),
        .wdata(s_tdata), .raddr(idx_reg[AW-1:0]), .rdata(rdata)
    );

    nhcd_div #(.NW(NW), .DW(IW)) u_ndiv (
        .clk(clk), .rst_n(rst_n), .start(go_reg), .num(dnum_reg),
        .den((state_reg == S_NA) ? ia_reg : ib_reg), .done(ndone), .quot(nquot)
    );

    nhcd_div #(.NW(ACC_W), .DW(Q_W+1)) u_tdiv (
        .clk(clk), .rst_n(rst_n), .start(tgo_reg), .num(tnum_reg),
        .den(tden_reg), .done(tdone), .quot(tquot)
    );

    assign nb  = nquot[Q_W-1:0];
    assign dd  = (na_reg >= nb) ? (na_reg - nb) : (nb - na_reg);
    assign fin = (acc_reg + 64'd128) >> 8;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            ia_reg     <= '0;
            ib_reg     <= '0;
            dvalid_reg <= 1'b0;
            duser_reg  <= 1'b0;
            dist_reg   <= '0;
            go_reg     <= 1'b0;
            tgo_reg    <= 1'b0;
        end
        else
        begin
            go_reg  <= 1'b0;
            tgo_reg <= 1'b0;
            if (out_load)
                dvalid_reg <= 1'b1;
            else if (m_tvalid && m_tready)
                dvalid_reg <= 1'b0;
            case (state_reg)
                S_LOAD:
                begin
                    if (acc_in)
                    begin
                        if (!full)
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                            ia_reg  <= ia_reg + IW'(s_tdata[BIN_W-1:0]);
                            ib_reg  <= ib_reg + IW'(s_tdata[2*BIN_W-1:BIN_W]);
                        end
                        if (s_tlast)
                        begin
                            idx_reg   <= '0;
                            acc_reg   <= '0;
                            state_reg <= S_RD;
                        end
                    end
                end
                S_RD:
                begin
                    // the RAM address is presented here, data comes next cycle
                    if (empty_in || (idx_reg == cnt_reg))
                        state_reg <= S_OUT;
                    else
                        state_reg <= S_FETCH;
                end
                S_FETCH:
                begin
                    state_reg <= S_NA;
                    go_reg    <= 1'b1;
                    dnum_reg  <= {rdata[BIN_W-1:0], 33'd0} >> 2;
                    rb_reg    <= rdata[2*BIN_W-1:BIN_W];
                end
                S_NA:
                begin
                    if (ndone)
                    begin
                        na_reg    <= nquot[Q_W-1:0];
                        dnum_reg  <= {rb_reg, 33'd0} >> 2;
                        go_reg    <= 1'b1;
                        state_reg <= S_NB;
                    end
                end
                S_NB:
                begin
                    if (ndone)
                    begin
                        if ((na_reg == '0) && (nb == '0))
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_RD;
                        end
                        else
                        begin
                            tnum_reg  <= 64'(dd) * 64'(dd);
                            tden_reg  <= (Q_W+1)'(na_reg) + (Q_W+1)'(nb);
                            tgo_reg   <= 1'b1;
                            state_reg <= S_TERM;
                        end
                    end
                end
                S_TERM:
                begin
                    if (tdone)
                    begin
                        acc_reg   <= acc_reg + tquot;
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        if (empty_in)
                            dist_reg <= '0;
                        else
                            dist_reg <= (fin > 64'(ONE_Q24)) ? ONE_Q24 : fin[DIST_W-1:0];
                        duser_reg <= empty_in;
                        cnt_reg   <= '0;
                        ia_reg    <= '0;
                        ib_reg    <= '0;
                        state_reg <= S_LOAD;
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    assign m_tvalid = dvalid_reg;
    assign m_tdata  = {7'd0, dist_reg};
    assign m_tuser  = duser_reg;

    // the bin count never passes the RAM depth
    property p_no_overflow;
        @(posedge clk) disable iff (!rst_n) cnt_reg <= CW'(MAX_BINS);
    endproperty
    assert property (p_no_overflow) else $error("bin count overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_LOAD) |-> !s_tready)
        else $error("input taken during walk");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |=> m_tvalid)
        else $error("result lost");
endmodule

// ===== rtl/nhcd_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on nhcd_pkg.
module nhcd_div import nhcd_pkg::*; #(
    parameter int NW = 64,
    parameter int DW = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quot
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] q_reg;
    logic [DW:0]   r_reg;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg, done_reg;
    logic [DW:0]   r_sh;

    assign r_sh = {r_reg[DW-1:0], q_reg[NW-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(NW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (run_reg)
        begin
            if (r_sh >= {1'b0, d_reg})
            begin
                r_reg <= r_sh - {1'b0, d_reg};
                q_reg <= {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_reg <= r_sh;
                q_reg <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

// ===== rtl/nhcd_mem.sv =====
// Bin pair store: one synchronous RAM, one write and one read port.
// Depends on nhcd_pkg.
module nhcd_mem import nhcd_pkg::*; #(
    parameter int DEPTH = MAX_BINS_D,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [AW-1:0]            waddr,
    input  logic [2*BIN_W-1:0]       wdata,
    input  logic [AW-1:0]            raddr,
    output logic [2*BIN_W-1:0]       rdata
);
    logic [2*BIN_W-1:0] mem [DEPTH];
    logic [2*BIN_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== verif/tb.sv =====
// Testbench for normalized_histogram_chi2_distance: directed and random bin-pair
// frames go in, and each distance beat is checked against a built-in predictor.
// Depends on nhcd_pkg and the RTL top level; reads no files.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import nhcd_pkg::*;

    localparam int  HIST_DEPTH = 64;
    localparam int  HOLD_LEN   = 3000;
    localparam int  LIMIT      = 4000000;
    localparam logic [BIN_W-1:0] BIN_MAX = {BIN_W{1'b1}};

    typedef struct packed {
        logic [BIN_W-1:0] a;
        logic [BIN_W-1:0] b;
        logic             last;
    } bin_pair_t;

    typedef struct packed {
        logic [DIST_W-1:0] score;
        logic              empty;
    } chi2_res_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;

    bin_pair_t pair_q[$];
    chi2_res_t chi2_q[$];
    bin_pair_t drv_pair;
    int        send_idle;
    int        recv_idle;
    bit        hold_send;
    bit        hold_req;
    bit        hold_used;
    int        hold_left;
    bit        beat_taken;
    int        mismatches;
    int        cycles;

    // predictor state
    logic [BIN_W-1:0] hist_a[HIST_DEPTH];
    logic [BIN_W-1:0] hist_b[HIST_DEPTH];
    longint unsigned  sum_a;
    longint unsigned  sum_b;
    int               n_bins;

    normalized_histogram_chi2_distance DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic chi2_res_t chi2_distance();
        chi2_res_t       r;
        longint unsigned acc;
        longint unsigned na;
        longint unsigned nb;
        longint unsigned d;
        acc = 0;
        if (sum_a == 0 || sum_b == 0)
        begin
            r.score = '0;
            r.empty = 1'b1;
            return r;
        end
        for (int i = 0; i < n_bins; i++)
        begin
            na = (longint'(hist_a[i]) << 31) / sum_a;
            nb = (longint'(hist_b[i]) << 31) / sum_b;
            d  = (na >= nb) ? na - nb : nb - na;
            if (na + nb != 0)
                acc += (d * d) / (na + nb);
        end
        acc = (acc + 128) >> 8;
        if (acc > ONE_Q24)
            acc = ONE_Q24;
        r.score = acc[DIST_W-1:0];
        r.empty = 1'b0;
        return r;
    endfunction

    task automatic load_pair(input bin_pair_t p);
        if (n_bins < HIST_DEPTH)
        begin
            hist_a[n_bins] = p.a;
            hist_b[n_bins] = p.b;
            sum_a += p.a;
            sum_b += p.b;
            n_bins++;
        end
        if (p.last)
        begin
            chi2_q.insert(chi2_q.size(), chi2_distance());
            sum_a  = 0;
            sum_b  = 0;
            n_bins = 0;
        end
    endtask

    function automatic logic [BIN_W-1:0] rand_bin();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return BIN_MAX;
            2: return BIN_W'($urandom_range(0, 255));
            default: return BIN_W'($urandom);
        endcase
    endfunction

    task automatic push_frame(input int len);
        bin_pair_t p;
        for (int i = 0; i < len; i++)
        begin
            p.a    = rand_bin();
            p.b    = rand_bin();
            p.last = (i == len - 1);
            pair_q.insert(pair_q.size(), p);
        end
    endtask

    task automatic push_pair(input logic [BIN_W-1:0] a, input logic [BIN_W-1:0] b,
                             input logic last);
        bin_pair_t p;
        p.a    = a;
        p.b    = b;
        p.last = last;
        pair_q.insert(pair_q.size(), p);
    endtask

    // accept detection and result checking at the rising edge
    always @(posedge clk)
    begin
        chi2_res_t exp_r;
        beat_taken <= rst_n && s_tvalid && s_tready;
        if (rst_n)
        begin
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            if (s_tvalid && s_tready)
                load_pair(drv_pair);
            if (m_tvalid && m_tready)
            begin
                if (chi2_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: tdata=%h tuser=%b", m_tdata, m_tuser);
                end
                else
                begin
                    exp_r = chi2_q.pop_front();
                    if (m_tdata !== {7'b0, exp_r.score} || m_tuser !== exp_r.empty)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp dist=%0d empty=%b, got tdata=%h tuser=%b",
                                     exp_r.score, exp_r.empty, m_tdata, m_tuser);
                    end
                end
            end
        end
    end

    // sender: advance on a taken beat, drop valid when idle
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || beat_taken))
        begin
            if (!hold_send && pair_q.size() > 0 && $urandom_range(0, 99) >= send_idle)
            begin
                drv_pair = pair_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {drv_pair.b, drv_pair.a};
                s_tlast  <= drv_pair.last;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver, with one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req && !hold_used)
            begin
                hold_used = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        m_tready   = 1'b0;
        send_idle  = 0;
        recv_idle  = 0;
        hold_send  = 1'b0;
        hold_req   = 1'b0;
        hold_used  = 1'b0;
        hold_left  = 0;
        beat_taken = 1'b0;
        mismatches = 0;
        cycles     = 0;
        sum_a      = 0;
        sum_b      = 0;
        n_bins     = 0;
        repeat (9) @(posedge clk);
        rst_n = 1'b0;
        @(negedge clk);
        rst_n = 1'b1;

        // directed frames
        push_pair(BIN_MAX, BIN_MAX, 1'b1);          // one bin, identical
        push_pair('0, '0, 1'b1);                    // both empty
        push_pair('0, 24'd5, 1'b0);                 // tested histogram empty
        push_pair('0, 24'd9, 1'b1);
        push_pair(BIN_MAX, '0, 1'b0);               // disjoint: saturates at 1.0
        push_pair('0, BIN_MAX, 1'b1);
        push_pair(24'd1, 24'd3, 1'b0);              // zero bin pair in the middle
        push_pair('0, '0, 1'b0);
        push_pair(24'd7, 24'd1, 1'b0);
        push_pair(BIN_MAX, 24'd1, 1'b1);
        push_pair(24'h800000, 24'h7FFFFF, 1'b0);
        push_pair(24'h555555, 24'hAAAAAA, 1'b0);
        push_pair(24'hAAAAAA, 24'h555555, 1'b1);
        push_pair(24'd3, '0, 1'b1);                 // reference histogram empty

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle = (ph == 1 || ph == 3) ? ((ph == 1) ? 56 : 37) : 0;
            recv_idle = (ph == 2 || ph == 3) ? ((ph == 2) ? 56 : 37) : 0;
            while (pair_q.size() < 500)
            begin
                case ($urandom_range(0, 99))
                    0, 1:    push_frame($urandom_range(65, 70));  // overflow past depth
                    2, 3, 4, 5, 6, 7, 8, 9:
                             push_frame($urandom_range(9, 64));
                    default: push_frame($urandom_range(1, 8));
                endcase
            end
            if (ph == 0)
                hold_req = 1'b1;
            wait (pair_q.size() == 0);
            if (ph == 1)
            begin
                // pause until every result is out
                hold_send = 1'b1;
                wait (!s_tvalid && chi2_q.size() == 0);
                @(negedge clk);
                hold_send = 1'b0;
            end
        end

        wait (pair_q.size() == 0 && !s_tvalid && chi2_q.size() == 0);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && chi2_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ===== normalized_histogram_chi2_distance.f =====
rtl/nhcd_pkg.sv
rtl/nhcd_div.sv
rtl/nhcd_mem.sv
rtl/normalized_histogram_chi2_distance.sv
verif/tb.sv
